// ===== rtl/erp_pkg.sv =====
// ----------------------------------------------------------------------------
// erp_pkg
// Shared types and constants for the echo pulse ranger.
// ----------------------------------------------------------------------------
package erp_pkg;

  localparam int unsigned CountW    = 16;
  localparam int unsigned OvfW      = 6;
  localparam int unsigned DistW     = 30;
  localparam int unsigned TicksW    = OvfW + CountW;
  localparam int unsigned UmPerTickW = 8;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 40;

  localparam logic [OvfW-1:0]       OvfMax    = 6'h3F;
  localparam logic [CountW-1:0]     CountMax  = 16'hFFFF;
  localparam logic [UmPerTickW-1:0] UmPerTick = 8'd170;

  localparam logic [DistW-1:0] MinDistReset = 30'd10000;
  localparam logic [DistW-1:0] MaxDistReset = 30'd10000000;

  localparam logic [CfgIdxW-1:0] CfgMinDist = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxDist = 8'd1;

  typedef enum logic {
    OpTimerEvent = 1'b0,
    OpRead       = 1'b1
  } erp_op_e;

  typedef struct packed {
    erp_op_e           operation;
    logic              update_event;
    logic              capture_event;
    logic [CountW-1:0] capture_count;
  } erp_item_t;

  typedef struct packed {
    logic              pulse_done;
    logic              pulse_started;
    logic [OvfW-1:0]   overflow_count;
    logic [CountW-1:0] pulse_count;
  } erp_state_t;

  typedef struct packed {
    logic [DistW-1:0] distance_um;
    logic             distance_valid;
    logic             fire_trigger;
    logic             clear_counter;
    logic             expect_falling;
    logic             polarity_change;
  } erp_result_t;

endpackage

// ===== rtl/erp_range.sv =====
// ----------------------------------------------------------------------------
// erp_range
// Converts pulse ticks to micrometres and checks the configured window.
// ----------------------------------------------------------------------------
module erp_range import erp_pkg::*; (
  input  logic [TicksW-1:0] ticks_i,
  input  logic [DistW-1:0]  min_dist_i,
  input  logic [DistW-1:0]  max_dist_i,
  output logic [DistW-1:0]  dist_um_o,
  output logic              in_range_o
);

  localparam int unsigned ProdW = TicksW + UmPerTickW;

  logic [ProdW-1:0] prod;

  // max ticks * 170 stays below 2^30
  assign prod       = ProdW'(ticks_i) * ProdW'(UmPerTick);
  assign dist_um_o  = prod[DistW-1:0];
  assign in_range_o = (dist_um_o > min_dist_i) && (dist_um_o < max_dist_i);

endmodule

// ===== rtl/erp_pulse.sv =====
// ----------------------------------------------------------------------------
// erp_pulse
// Echo pulse state and per-item result logic.
// ----------------------------------------------------------------------------
module erp_pulse import erp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  erp_item_t        item_i,
  input  logic [DistW-1:0] min_dist_i,
  input  logic [DistW-1:0] max_dist_i,
  output erp_result_t      res_o
);

  erp_state_t       st_q, st_d;
  logic [DistW-1:0] dist_um;
  logic             in_range;

  erp_range u_range (
    .ticks_i    ({st_q.overflow_count, st_q.pulse_count}),
    .min_dist_i (min_dist_i),
    .max_dist_i (max_dist_i),
    .dist_um_o  (dist_um),
    .in_range_o (in_range)
  );

  always_comb begin
    st_d  = st_q;
    res_o = '0;
    if (item_i.operation == OpRead) begin
      res_o.fire_trigger = 1'b1;
      if (st_q.pulse_done) begin
        if (in_range) begin
          res_o.distance_um    = dist_um;
          res_o.distance_valid = 1'b1;
        end
        st_d.pulse_done     = 1'b0;
        st_d.pulse_started  = 1'b0;
        st_d.overflow_count = '0;
      end
    end else if (!st_q.pulse_done) begin
      if (item_i.update_event && st_q.pulse_started) begin
        if (st_q.overflow_count == OvfMax) begin
          st_d.pulse_done  = 1'b1;
          st_d.pulse_count = CountMax;
        end else begin
          st_d.overflow_count = st_q.overflow_count + OvfW'(1);
        end
      end
      if (item_i.capture_event) begin
        res_o.polarity_change = 1'b1;
        if (st_q.pulse_started) begin
          st_d.pulse_done  = 1'b1;
          st_d.pulse_count = item_i.capture_count;
        end else begin
          st_d.pulse_done     = 1'b0;
          st_d.overflow_count = '0;
          st_d.pulse_count    = '0;
          st_d.pulse_started  = 1'b1;
          res_o.clear_counter  = 1'b1;
          res_o.expect_falling = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ===== rtl/ultrasonic_echo_pulse_ranger_core.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_pulse_ranger_core
// Path: input register, then result register, from input accept to result valid.
// Throughput: one item per cycle unless the output stalls; pulse state
// updates as an item leaves the input register, one multiply by 170 and a
// window compare on that path. Reset: asynchronous active low; pulse state
// cleared, window set to 10 mm and 10 m, both stages empty.
// ----------------------------------------------------------------------------
module ultrasonic_echo_pulse_ranger_core import erp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] update_event, [1] capture_event, [17:2] capture_count, rest zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [29:0] distance_um, [30] fire_trigger, [31] clear_counter,
  // [32] expect_falling, [33] polarity_change, rest zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] distance_valid
  output logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic             in_vld_q;
  erp_item_t        in_q;
  logic             out_vld_q;
  erp_result_t      out_q;
  erp_result_t      res;
  logic             adv;
  logic [DistW-1:0] min_dist_q, max_dist_q;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= MinDistReset;
      max_dist_q <= MaxDistReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgMinDist) begin
        min_dist_q <= cfg_data_i[DistW-1:0];
      end
      if (cfg_index_i == CfgMaxDist) begin
        max_dist_q <= cfg_data_i[DistW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.operation     <= erp_op_e'(s_axis_tuser);
      in_q.update_event  <= s_axis_tdata[0];
      in_q.capture_event <= s_axis_tdata[1];
      in_q.capture_count <= s_axis_tdata[CountW+1:2];
    end
  end

  erp_pulse u_pulse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .item_i     (in_q),
    .min_dist_i (min_dist_q),
    .max_dist_i (max_dist_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.distance_valid;
  assign m_axis_tdata  = {6'b0, out_q.polarity_change, out_q.expect_falling,
                          out_q.clear_counter, out_q.fire_trigger, out_q.distance_um};

endmodule

// ===== rtl/erp_checker.sv =====
// ----------------------------------------------------------------------------
// erp_checker
// Port-level checks on the ranger result stream.
// ----------------------------------------------------------------------------
module erp_checker import erp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_valid_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[30] && (m_axis_tdata[29:0] != 30'd0))
    else $error("valid distance without read");

  a_timer_no_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[30] |->
      (m_axis_tdata[29:0] == 30'd0) && !m_axis_tuser)
    else $error("distance on timer item");

  a_clear_polarity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[32] && m_axis_tdata[33])
    else $error("counter clear without falling polarity");

  a_read_no_polarity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[30] |-> !m_axis_tdata[31] && !m_axis_tdata[33])
    else $error("polarity change on read item");

endmodule

bind ultrasonic_echo_pulse_ranger_core erp_checker u_erp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
